// ===== design/decimal_string_formatter_macros.svh =====
// ----------------------------------------------------------------------------
// decimal_string_formatter_macros.svh
// Assertion macros shared by the formatter's checker.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_STRING_FORMATTER_MACROS_SVH
`define DECIMAL_STRING_FORMATTER_MACROS_SVH

// Concurrent assertion sampled on the rising clock, off while reset is low.
`define DSF_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

// Same, for a property that must hold on every beat shown on the result side.
`define DSF_ASSERT_BEAT(lbl, clk, rstn, vld, prop, msg) \
    `DSF_ASSERT(lbl, clk, rstn, (vld) |-> (prop), msg)

`endif

// ===== design/dsf_pkg.sv =====
// ----------------------------------------------------------------------------
// dsf_pkg
// Widths and character codes of the decimal string formatter.
// ----------------------------------------------------------------------------
package dsf_pkg;

    localparam int VALUE_W    = 32;   // binary input width
    localparam int PLACES_W   = 4;    // decimal_places field width
    localparam int CHAR_W     = 6;    // ASCII code field width
    localparam int INT_DIGITS = 10;   // decimal digits of a 32-bit value
    localparam int BCD_W      = 4 * INT_DIGITS;

    localparam int MAX_FRACTION_DIGITS_DEF = 15;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_POINT = 6'd46;

endpackage

// ===== design/decimal_string_formatter.sv =====
// ----------------------------------------------------------------------------
// decimal_string_formatter
// Unsigned 32-bit value to fixed-point decimal ASCII text, one char per beat.
// ----------------------------------------------------------------------------
// One input beat carries a value and a count of decimal places; the block
// answers with the decimal text, most significant character first, tlast on
// the final character. With more digits than places the point goes before
// the last places digits (none when places is 0); otherwise the text is
// "0." followed by padding zeros and the digits. A zero value gives a lone
// "0". Places above MAX_FRACTION_DIGITS are clamped to it. Timing: after an
// input beat is taken the value is converted to BCD by a shift-and-add-3
// unit, one input bit per cycle, the scan state then finds the digit
// count, and one character per cycle goes to the output register as long
// as the sink takes it. No new input beat is taken while an item is in
// work; s_tready comes back once the last character is in the output
// register, while that beat may still be waiting.
// ----------------------------------------------------------------------------
module decimal_string_formatter #(
    parameter int MAX_FRACTION_DIGITS = dsf_pkg::MAX_FRACTION_DIGITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // [31:0] value, [35:32] decimal_places, rest 0
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [5:0] character, rest 0
    output logic        m_tlast
);

    localparam int VW  = dsf_pkg::VALUE_W;
    localparam int BW  = dsf_pkg::BCD_W;
    localparam int CW  = dsf_pkg::CHAR_W;
    localparam int ND  = dsf_pkg::INT_DIGITS;
    // places register width, after clamping
    localparam int PL_W = $clog2(MAX_FRACTION_DIGITS + 1);
    // highest digit position ever emitted (1-based)
    localparam int POS_MAX = (MAX_FRACTION_DIGITS + 1 > ND) ? MAX_FRACTION_DIGITS + 1 : ND;
    localparam int POS_W   = $clog2(POS_MAX + 1);
    localparam int CNT_W   = $clog2(VW);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    // control
    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_tvalid_reg, m_tvalid_next;
    // datapath
    logic [VW-1:0]    val_reg, val_next;
    logic [BW-1:0]    bcd_reg, bcd_next;
    logic [PL_W-1:0]  places_reg, places_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             point_reg, point_next;
    logic [CW-1:0]    char_reg, char_next;
    logic             last_reg, last_next;

    logic [31:0]      sat_places;
    logic [BW-1:0]    bcd_adj;
    logic [3:0]       nd;
    logic [3:0]       cur_digit;
    logic [POS_W-1:0] pos_idx;
    logic             out_free;
    logic             accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(8 - CW){1'b0}}, char_reg};
    assign m_tlast  = last_reg;

    // clamp places to the configured maximum
    assign sat_places = (32'(s_tdata[35:32]) > 32'(MAX_FRACTION_DIGITS))
                      ? 32'(MAX_FRACTION_DIGITS) : 32'(s_tdata[35:32]);

    // add-3 step of the shift-and-add-3 unit, all digits in parallel
    always_comb begin
        for (int i = 0; i < ND; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end else begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    // number of significant decimal digits
    always_comb begin
        nd = 4'd0;
        for (int i = 0; i < ND; i++) begin
            if (bcd_reg[4*i +: 4] != 4'd0) begin
                nd = 4'(i + 1);
            end
        end
    end

    // digit at position pos_reg (1 = least significant); zero above the BCD
    assign pos_idx = pos_reg - POS_W'(1);
    always_comb begin
        cur_digit = 4'd0;
        for (int i = 0; i < ND; i++) begin
            if (pos_idx == POS_W'(i)) begin
                cur_digit = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg;
        val_next      = val_reg;
        bcd_next      = bcd_reg;
        places_next   = places_reg;
        pos_next      = pos_reg;
        point_next    = point_reg;
        char_next     = char_reg;
        last_next     = last_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    val_next    = s_tdata[31:0];
                    places_next = sat_places[PL_W-1:0];
                    bcd_next    = '0;
                    cnt_next    = '0;
                    state_next  = ST_CONV;
                end
            end
            ST_CONV: begin
                bcd_next = {bcd_adj[BW-2:0], val_reg[VW-1]};
                val_next = {val_reg[VW-2:0], 1'b0};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(VW - 1)) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                point_next = 1'b0;
                if (nd == 4'd0) begin
                    // zero value: a lone '0'
                    pos_next    = POS_W'(1);
                    places_next = '0;
                end else if (POS_W'(nd) > POS_W'(places_reg)) begin
                    pos_next = POS_W'(nd);
                end else begin
                    // leading '0' before the point, padding zeros follow
                    pos_next = POS_W'(places_reg) + POS_W'(1);
                end
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    if (point_reg) begin
                        char_next  = dsf_pkg::CHAR_POINT;
                        last_next  = 1'b0;
                        point_next = 1'b0;
                    end else begin
                        char_next  = dsf_pkg::CHAR_ZERO + {2'b00, cur_digit};
                        last_next  = (pos_reg == POS_W'(1));
                        pos_next   = pos_idx;
                        point_next = (places_reg != '0) && (pos_idx == POS_W'(places_reg));
                        if (pos_reg == POS_W'(1)) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg    <= val_next;
        bcd_reg    <= bcd_next;
        places_reg <= places_next;
        pos_reg    <= pos_next;
        point_reg  <= point_next;
        char_reg   <= char_next;
        last_reg   <= last_next;
    end

endmodule

// ===== design/dsf_checker.sv =====
// ----------------------------------------------------------------------------
// dsf_checker
// Port-level checks of the decimal string formatter, bound to the top level.
// ----------------------------------------------------------------------------
`include "decimal_string_formatter_macros.svh"

module dsf_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // a stalled result beat holds
    `DSF_ASSERT(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result beat changed while stalled")

    // every character is a digit or the point, upper bits zero
    `DSF_ASSERT_BEAT(a_char, aclk, aresetn, m_tvalid, (m_tdata[7:6] == 2'b00) && ((m_tdata[5:0] == dsf_pkg::CHAR_POINT) || ((m_tdata[5:0] >= dsf_pkg::CHAR_ZERO) && (m_tdata[5:0] <= dsf_pkg::CHAR_ZERO + 6'd9))), "bad character code")

    // text never ends on the point
    `DSF_ASSERT_BEAT(a_point, aclk, aresetn, m_tvalid && (m_tdata[5:0] == dsf_pkg::CHAR_POINT), !m_tlast, "point marked last")

    // busy converting right after an input beat
    `DSF_ASSERT(a_busy, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "ready right after accept")

endmodule

bind decimal_string_formatter dsf_checker u_dsf_checker (.*);
